// ----- rtl/core/ufe_pkg.sv -----
// ufe_pkg: shared types, constants and the CRC step for the UECP frame encoder.
// Depends on nothing; used by ufe_front, ufe_back and uecp_frame_encoder_unit.
`timescale 1ns / 1ps
`default_nettype none

package ufe_pkg;

  // Default depth of the item queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // Framing marks.
  localparam logic [7:0] MarkStart = 8'hFE;
  localparam logic [7:0] MarkStop  = 8'hFF;
  localparam logic [7:0] MarkEsc   = 8'hFD;
  localparam logic [15:0] CrcInit  = 16'hFFFF;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] RegSite = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEnc  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSeq  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic [7:0] data_length;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [9:0] site_address;
    logic [5:0] encoder_address;
    logic [7:0] sequence_count;
  } cfg_t;

  // One byte of the CCITT CRC, byte-wise form.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c[7:0] = c[7:0] ^ b;
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ufe_front.sv -----
// ufe_front: accepts input words, drops words outside a frame, queues the rest.
// Depends on ufe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufe_front #(
  parameter int unsigned Depth = ufe_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ufe_pkg::item_t item_i,
  input  wire logic          pop_i,
  output ufe_pkg::head_t     head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  ufe_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic in_frame_q, in_frame_d;
  logic full, accept, keep, push, pop;

  assign full       = (count_q == CntW'(Depth));
  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;
  // a word with first clear outside a frame makes no output
  assign keep       = item_i.first | in_frame_q;
  assign push       = accept & keep;
  assign pop        = pop_i & (count_q != '0);

  always_comb begin
    in_frame_d = in_frame_q;
    if (push) begin
      in_frame_d = ~item_i.last;
    end
    wr_ptr_d = wr_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    rd_ptr_d = rd_ptr_q;
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
      in_frame_q <= 1'b0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
      in_frame_q <= in_frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- rtl/core/ufe_back.sv -----
// ufe_back: expands queued words into framed, escape-stuffed bytes with CRC.
// Depends on ufe_pkg; fed by ufe_front.
`timescale 1ns / 1ps
`default_nettype none

module ufe_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ufe_pkg::head_t head_i,
  output logic               pop_o,
  input  wire ufe_pkg::cfg_t cfg_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               out_run_last_o,
  output logic               out_frame_end_o
);

  localparam logic [3:0] StStart = 4'd0;
  localparam logic [3:0] StSite  = 4'd1;
  localparam logic [3:0] StAddr  = 4'd2;
  localparam logic [3:0] StSeq   = 4'd3;
  localparam logic [3:0] StLen   = 4'd4;
  localparam logic [3:0] StData  = 4'd5;
  localparam logic [3:0] StCrcHi = 4'd6;
  localparam logic [3:0] StCrcLo = 4'd7;
  localparam logic [3:0] StStop  = 4'd8;

  logic [3:0] step_q, step_d, cur_step, next_step;
  logic started_q, started_d, half_q, half_d;
  logic [15:0] crc_q, crc_d, fin;
  logic out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic out_run_last_q, out_run_last_d, out_frame_end_q, out_frame_end_d;
  logic out_ready, go;
  logic [7:0] byte_cur, emit_byte;
  logic is_raw, is_body, needs_esc, advance, done_item;

  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign go        = head_i.valid & out_ready;
  assign cur_step  = started_q ? step_q : (head_i.item.first ? StStart : StData);
  assign fin       = ~crc_q;

  always_comb begin
    byte_cur  = head_i.item.data_byte;
    is_raw    = 1'b0;
    is_body   = 1'b0;
    next_step = cur_step + 1'b1;
    case (cur_step)
      StStart: begin
        byte_cur = ufe_pkg::MarkStart;
        is_raw   = 1'b1;
      end
      StSite: begin
        byte_cur = cfg_i.site_address[9:2];
        is_body  = 1'b1;
      end
      StAddr: begin
        byte_cur = {cfg_i.site_address[1:0], cfg_i.encoder_address};
        is_body  = 1'b1;
      end
      StSeq: begin
        byte_cur = cfg_i.sequence_count;
        is_body  = 1'b1;
      end
      StLen: begin
        byte_cur = head_i.item.data_length;
        is_body  = 1'b1;
      end
      StData: begin
        byte_cur = head_i.item.data_byte;
        is_body  = 1'b1;
      end
      StCrcHi: byte_cur = fin[15:8];
      StCrcLo: byte_cur = fin[7:0];
      StStop: begin
        byte_cur = ufe_pkg::MarkStop;
        is_raw   = 1'b1;
      end
      default: byte_cur = head_i.item.data_byte;
    endcase
  end

  // FD/FE/FF go out as FD then 00/01/02
  assign needs_esc = ~is_raw & (byte_cur >= ufe_pkg::MarkEsc);

  always_comb begin
    if (half_q) begin
      emit_byte = {6'd0, byte_cur[1:0] - 2'b01};
      advance   = 1'b1;
    end else if (needs_esc) begin
      emit_byte = ufe_pkg::MarkEsc;
      advance   = 1'b0;
    end else begin
      emit_byte = byte_cur;
      advance   = 1'b1;
    end
  end

  assign done_item = advance &
      ((cur_step == StStop) | ((cur_step == StData) & ~head_i.item.last));
  assign pop_o = go & done_item;

  always_comb begin
    step_d          = step_q;
    started_d       = started_q;
    half_d          = half_q;
    crc_d           = crc_q;
    out_valid_d     = out_valid_q;
    out_byte_d      = out_byte_q;
    out_run_last_d  = out_run_last_q;
    out_frame_end_d = out_frame_end_q;
    if (go) begin
      half_d          = needs_esc & ~half_q;
      out_valid_d     = 1'b1;
      out_byte_d      = emit_byte;
      out_run_last_d  = done_item;
      out_frame_end_d = (cur_step == StStop);
      if (done_item) begin
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        step_d    = advance ? next_step : cur_step;
      end
      if (cur_step == StStart || cur_step == StStop) begin
        crc_d = ufe_pkg::CrcInit;
      end else if (is_body && !half_q) begin
        crc_d = ufe_pkg::crc_feed(crc_q, byte_cur);
      end
      if (cur_step == StData && advance && head_i.item.last) begin
        step_d = StCrcHi;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StStart;
      started_q   <= 1'b0;
      half_q      <= 1'b0;
      crc_q       <= ufe_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      started_q   <= started_d;
      half_q      <= half_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q      <= out_byte_d;
    out_run_last_q  <= out_run_last_d;
    out_frame_end_q <= out_frame_end_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_run_last_o  = out_run_last_q;
  assign out_frame_end_o = out_frame_end_q;

  a_stop_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_frame_end_o |-> out_byte_o == ufe_pkg::MarkStop && out_run_last_o)
    else $error("stop byte flagged on wrong value or not last of its word");

  a_half_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (half_q || started_q) |-> head_i.valid)
    else $error("word left the queue in the middle of its expansion");

  a_esc_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
      go && needs_esc && !half_q |=> half_q && !pop_o || (half_q && pop_o))
    else $error("escape byte not followed by its code");

endmodule

`default_nettype wire

// ----- rtl/core/uecp_frame_encoder_unit.sv -----
// uecp_frame_encoder_unit: top level of the UECP frame encoder.
// Depends on ufe_pkg, ufe_front and ufe_back.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | data_byte_i first_i last_i data_length_i
//  out     | source    | out_valid_o / out_stall_i| out_byte_o run_last_o frame_end_o
//  cfg     | sink      | cfg_we_i                 | cfg_idx_i cfg_data_i
//
// Output: the back end sends one byte per cycle while a word is queued and
//   the output is not stalled; a plain data word expands to 1..2 output bytes,
//   a first+last word to up to 16.
// The input queue (Depth words) takes words while the back end still works.
// Words with first clear outside a frame are taken while the queue is not full and dropped.
// Reset is asynchronous and clears control state and the config registers.
// A stall on the output holds the output register; the queue absorbs input.
`timescale 1ns / 1ps
`default_nettype none

module uecp_frame_encoder_unit #(
  parameter int unsigned Depth = ufe_pkg::QueueDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [ufe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ufe_pkg::CfgDataW-1:0]  cfg_data_i,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          first_i,
  input  wire logic                          last_i,
  input  wire logic [7:0]                    data_length_i,
  // output words
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         out_byte_o,
  output logic                               run_last_o,
  output logic                               frame_end_o
);

  ufe_pkg::cfg_t  cfg_q, cfg_d;
  ufe_pkg::item_t item;
  ufe_pkg::head_t head;
  logic pop;

  // Config registers; the user writes them only while no word is in flight (not enforced here).
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ufe_pkg::RegSite: cfg_d.site_address    = cfg_data_i;
        ufe_pkg::RegEnc:  cfg_d.encoder_address = cfg_data_i[5:0];
        ufe_pkg::RegSeq:  cfg_d.sequence_count  = cfg_data_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign item.data_byte   = data_byte_i;
  assign item.first       = first_i;
  assign item.last        = last_i;
  assign item.data_length = data_length_i;

  // Front: accept, filter and queue words.
  ufe_front #(
    .Depth(Depth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item),
    .pop_i      (pop),
    .head_o     (head)
  );

  // Back: header, data, CRC, stop byte, escape stuffing.
  ufe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .cfg_i           (cfg_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .out_run_last_o  (run_last_o),
    .out_frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire
